// ----- rtl/weighted_adjacency_list_store_top_defines.svh -----
// ----------------------------------------------------------------------------
// weighted adjacency list store assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ADJACENCY_LIST_STORE_TOP_DEFINES_SVH
`define WEIGHTED_ADJACENCY_LIST_STORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold on every clock edge out of reset
`define WAL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("wal assertion failed");
// consequent must hold in the cycle after the antecedent
`define WAL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wal assertion failed");
`else
`define WAL_ASSERT(label, clk, rstn, prop)
`define WAL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/wal_pkg.sv -----
// ----------------------------------------------------------------------------
// wal_pkg
// shared field widths, command and status codes, list entry layout
// ----------------------------------------------------------------------------
`default_nettype none

package wal_pkg;

    localparam int CMD_W    = 2;
    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   neighbour;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- rtl/wal_ram.sv -----
// ----------------------------------------------------------------------------
// wal_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/weighted_adjacency_list_store_top.sv -----
// sequencing: clear, rejected and unused commands go from accept straight to ST_RESP;
//   lookup passes ST_LEN and ST_SCAN, add also ST_WB unless full, then ST_RESP and m_valid
// one command at a time: s_ready only in ST_IDLE, and ST_RESP waits out m_ready stalls;
//   the scan uses one neighbour comparator walking the list one entry per cycle
// reset: synchronous active low, empties all lists at once via per-node valid bits,
//   node count back to 64, no memory clearing pass
// ----------------------------------------------------------------------------
// weighted_adjacency_list_store_top
// directed weighted graph kept as per-node adjacency lists with add and lookup
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_adjacency_list_store_top_defines.svh"

module weighted_adjacency_list_store_top #(
    parameter int NODES      = 64,
    parameter int MAX_DEGREE = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write channel, node count
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wal_pkg::CNT_W-1:0]     cfg_data,
    // command beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [wal_pkg::CMD_W-1:0]     s_command,
    input  wire logic [wal_pkg::NODE_W-1:0]    s_src_node,
    input  wire logic [wal_pkg::NODE_W-1:0]    s_dest_node,
    input  wire logic signed [wal_pkg::WEIGHT_W-1:0] s_edge_weight,
    // result beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic signed [wal_pkg::WEIGHT_W-1:0] m_weight_out,
    output logic [wal_pkg::STATUS_W-1:0]       m_status
);

    // only node numbers that fit the 6 bit field can ever hold a list
    localparam int NODE_SPAN = 1 << wal_pkg::NODE_W;
    localparam int LEN_DEPTH = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
    localparam int LEN_AW    = (LEN_DEPTH > 1) ? $clog2(LEN_DEPTH) : 1;
    localparam int LEN_W     = $clog2(MAX_DEGREE + 1);
    localparam int ENT_DEPTH = LEN_DEPTH * MAX_DEGREE;
    localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_SCAN,
        ST_WB,
        ST_RESP
    } state_t;

    state_t                            state_reg, state_next;
    logic [wal_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LEN_DEPTH-1:0]              valid_reg, valid_next;
    logic [wal_pkg::CMD_W-1:0]         cmd_reg, cmd_next;
    logic [wal_pkg::NODE_W-1:0]        src_reg, src_next;
    logic [wal_pkg::NODE_W-1:0]        dest_reg, dest_next;
    logic [wal_pkg::WEIGHT_W-1:0]      wt_reg, wt_next;
    logic [ENT_AW-1:0]                 base_reg, base_next;
    logic [LEN_W-1:0]                  len_reg, len_next;
    logic [LEN_W-1:0]                  idx_reg, idx_next;
    logic [LEN_W-1:0]                  cmp_idx_reg, cmp_idx_next;
    logic                              cmp_pend_reg, cmp_pend_next;
    logic [LEN_W-1:0]                  wb_idx_reg, wb_idx_next;
    logic                              append_reg, append_next;
    logic                              res_found_reg, res_found_next;
    logic [wal_pkg::WEIGHT_W-1:0]      res_weight_reg, res_weight_next;
    logic [wal_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              m_found_reg, m_found_next;
    logic [wal_pkg::WEIGHT_W-1:0]      m_weight_reg, m_weight_next;
    logic [wal_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;

    // list length ram ports
    logic                              len_rd_en;
    logic [LEN_AW-1:0]                 len_rd_addr;
    logic [LEN_W-1:0]                  len_rdata;
    logic                              len_wr_en;
    logic [LEN_AW-1:0]                 src_idx;

    // entry ram ports
    logic                              ent_rd_en;
    logic [ENT_AW-1:0]                 ent_rd_addr;
    logic [wal_pkg::ENTRY_W-1:0]       ent_rdata;
    wal_pkg::entry_t                   ent_rd;
    wal_pkg::entry_t                   ent_wr;
    logic                              ent_wr_en;
    logic [ENT_AW-1:0]                 ent_wr_addr;

    logic                              accept;
    logic                              out_of_range;
    logic                              issue;
    logic                              hit;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_weight_out = m_weight_reg;
    assign m_status     = m_status_reg;

    assign accept  = s_valid && s_ready;
    assign src_idx = src_reg[LEN_AW-1:0];
    assign ent_rd  = ent_rdata;

    // node numbers at or above min(node count, NODES) are rejected
    assign out_of_range = ({1'b0, s_src_node} >= cnt_reg)
                       || ({1'b0, s_dest_node} >= cnt_reg)
                       || (32'(s_src_node) >= NODES)
                       || (32'(s_dest_node) >= NODES);

    // list length read is launched on the accept beat, data lands in ST_LEN
    assign len_rd_en   = accept;
    assign len_rd_addr = s_src_node[LEN_AW-1:0];
    assign len_wr_en   = (state_reg == ST_WB) && append_reg;

    // scan: one entry read issued per cycle, compared the cycle after
    assign issue       = (idx_reg < len_reg);
    assign hit         = cmp_pend_reg && (ent_rd.neighbour == dest_reg);
    assign ent_rd_en   = (state_reg == ST_SCAN) && issue;
    assign ent_rd_addr = base_reg + ENT_AW'(idx_reg);

    // write back either overwrites the matched slot or appends at the tail
    assign ent_wr_en        = (state_reg == ST_WB);
    assign ent_wr_addr      = base_reg + ENT_AW'(wb_idx_reg);
    assign ent_wr.neighbour = dest_reg;
    assign ent_wr.weight    = wt_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        cmd_next        = cmd_reg;
        src_next        = src_reg;
        dest_next       = dest_reg;
        wt_next         = wt_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        wb_idx_next     = wb_idx_reg;
        append_next     = append_reg;
        res_found_next  = res_found_reg;
        res_weight_next = res_weight_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_weight_next   = m_weight_reg;
        m_status_next   = m_status_reg;

        if (cfg_valid && cfg_ready) begin
            cnt_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next        = s_command;
                    src_next        = s_src_node;
                    dest_next       = s_dest_node;
                    wt_next         = s_edge_weight;
                    base_next       = ENT_AW'(s_src_node[LEN_AW-1:0]) * ENT_AW'(MAX_DEGREE);
                    res_found_next  = 1'b0;
                    res_weight_next = '0;
                    res_status_next = wal_pkg::STATUS_OK;
                    state_next      = ST_RESP;
                    case (s_command)
                        wal_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                        end
                        wal_pkg::CMD_ADD, wal_pkg::CMD_LOOKUP: begin
                            if (out_of_range) begin
                                res_status_next = wal_pkg::STATUS_RANGE;
                            end else begin
                                state_next = ST_LEN;
                            end
                        end
                        default: begin
                            res_status_next = wal_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                len_next      = valid_reg[src_idx] ? len_rdata : '0;
                idx_next      = '0;
                cmp_pend_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    res_found_next = 1'b1;
                    if (cmd_reg == wal_pkg::CMD_LOOKUP) begin
                        res_weight_next = ent_rd.weight;
                        state_next      = ST_RESP;
                    end else begin
                        wb_idx_next = cmp_idx_reg;
                        append_next = 1'b0;
                        state_next  = ST_WB;
                    end
                end else if (!issue && !cmp_pend_reg) begin
                    if (cmd_reg == wal_pkg::CMD_LOOKUP) begin
                        state_next = ST_RESP;
                    end else if (len_reg == LEN_W'(MAX_DEGREE)) begin
                        res_status_next = wal_pkg::STATUS_FULL;
                        state_next      = ST_RESP;
                    end else begin
                        wb_idx_next = len_reg;
                        append_next = 1'b1;
                        state_next  = ST_WB;
                    end
                end else begin
                    cmp_pend_next = issue;
                    cmp_idx_next  = idx_reg;
                    idx_next      = idx_reg + LEN_W'(issue);
                end
            end
            ST_WB: begin
                if (append_reg) begin
                    valid_next[src_idx] = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // output register frees while the previous beat is taken
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_weight_next = res_weight_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= wal_pkg::CNT_RESET;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
            len_reg      <= '0;
            idx_reg      <= '0;
            append_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
            cmp_pend_reg <= cmp_pend_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            append_reg   <= append_next;
        end
        cmd_reg        <= cmd_next;
        src_reg        <= src_next;
        dest_reg       <= dest_next;
        wt_reg         <= wt_next;
        base_reg       <= base_next;
        cmp_idx_reg    <= cmp_idx_next;
        wb_idx_reg     <= wb_idx_next;
        res_found_reg  <= res_found_next;
        res_weight_reg <= res_weight_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_weight_reg   <= m_weight_next;
        m_status_reg   <= m_status_next;
    end

    // per-node list lengths
    wal_ram #(
        .WIDTH (LEN_W),
        .DEPTH (LEN_DEPTH)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (len_wr_en),
        .wr_addr (src_idx),
        .wr_data (len_reg + LEN_W'(1)),
        .rd_en   (len_rd_en),
        .rd_addr (len_rd_addr),
        .rd_data (len_rdata)
    );

    // (neighbour, weight) entries, MAX_DEGREE slots per node
    wal_ram #(
        .WIDTH (wal_pkg::ENTRY_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rdata)
    );

    // one command in flight at a time
    `WAL_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a list never grows past its slot count
    `WAL_ASSERT(a_len_bound, aclk, aresetn, len_reg <= LEN_W'(MAX_DEGREE))
    // an append only happens into a free slot
    `WAL_ASSERT(a_append_room, aclk, aresetn,
                !(state_reg == ST_WB && append_reg) || (wb_idx_reg < LEN_W'(MAX_DEGREE)))
    // a finished result always reaches the output register and frees the block
    `WAL_ASSERT_NEXT(a_resp_loads, aclk, aresetn, state_reg == ST_RESP && (!m_valid_reg || m_ready), m_valid_reg && s_ready)

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted adjacency list store testbench
// random and directed graph commands against a mirror of the adjacency lists,
// each result beat checked in order, with sender gaps and receiver stalls
// ----------------------------------------------------------------------------

module tb;

    localparam int NODES   = 64;
    localparam int MAX_DEG = 16;

    // command code the block answers but otherwise ignores
    localparam logic [wal_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // receiver long hold-off: starts after this many accepted commands
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 600;

    // cycles with no beat on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTS     = 200;

    typedef struct packed {
        logic [wal_pkg::CMD_W-1:0]    command;
        logic [wal_pkg::NODE_W-1:0]   src;
        logic [wal_pkg::NODE_W-1:0]   dest;
        logic [wal_pkg::WEIGHT_W-1:0] weight;
    } graph_cmd_t;

    typedef struct packed {
        logic                         found;
        logic [wal_pkg::WEIGHT_W-1:0] weight;
        logic [wal_pkg::STATUS_W-1:0] status;
    } graph_answer_t;

    // ------------------------------------------------------------------
    // block ports, every input known from time zero
    // ------------------------------------------------------------------
    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [wal_pkg::CNT_W-1:0]    cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [wal_pkg::CMD_W-1:0]    s_command = '0;
    logic [wal_pkg::NODE_W-1:0]   s_src_node = '0;
    logic [wal_pkg::NODE_W-1:0]   s_dest_node = '0;
    logic [wal_pkg::WEIGHT_W-1:0] s_edge_weight = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_found;
    logic [wal_pkg::WEIGHT_W-1:0] m_weight_out;
    logic [wal_pkg::STATUS_W-1:0] m_status;

    weighted_adjacency_list_store_top #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEG)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_src_node    (s_src_node),
        .s_dest_node   (s_dest_node),
        .s_edge_weight (s_edge_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_weight_out  (m_weight_out),
        .m_status      (m_status)
    );

    // 4 ns period
    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // mirror of the graph: list lengths, neighbours and weights per node
    // ------------------------------------------------------------------
    logic [4:0]                   mirror_len [NODES];
    logic [wal_pkg::NODE_W-1:0]   mirror_nbr [NODES][MAX_DEG];
    logic [wal_pkg::WEIGHT_W-1:0] mirror_wt  [NODES][MAX_DEG];
    logic [wal_pkg::CNT_W-1:0]    mirror_node_count;

    graph_cmd_t    cmd_q[$];     // commands waiting for the driver
    graph_answer_t answer_q[$];  // answers owed by the block, oldest first
    int            err_count = 0;
    int            answer_idx = 0;

    // applies one command to the mirror and returns the answer it owes
    function automatic graph_answer_t apply_graph_cmd(input graph_cmd_t c);
        graph_answer_t a;
        int lim;
        int slot;
        int n;
        a = '0;
        a.status = wal_pkg::STATUS_OK;
        lim = (mirror_node_count < NODES) ? int'(mirror_node_count) : NODES;
        // clear wipes every list, node count does not matter
        if (c.command == wal_pkg::CMD_CLEAR) begin
            for (n = 0; n < NODES; n++) mirror_len[n] = '0;
            return a;
        end
        if (c.command != wal_pkg::CMD_ADD && c.command != wal_pkg::CMD_LOOKUP) return a;
        // either end of the edge outside the nodes in use
        if (int'(c.src) >= lim || int'(c.dest) >= lim) begin
            a.status = wal_pkg::STATUS_RANGE;
            return a;
        end
        slot = -1;
        for (n = 0; n < int'(mirror_len[c.src]); n++)
            if (slot < 0 && mirror_nbr[c.src][n] == c.dest) slot = n;
        if (c.command == wal_pkg::CMD_LOOKUP) begin
            if (slot >= 0) begin
                a.found  = 1'b1;
                a.weight = mirror_wt[c.src][slot];
            end
            return a;
        end
        if (slot >= 0) begin
            // existing edge, weight overwritten in place
            mirror_wt[c.src][slot] = c.weight;
            a.found = 1'b1;
        end else if (int'(mirror_len[c.src]) >= MAX_DEG) begin
            // new neighbour on a full list is dropped
            a.status = wal_pkg::STATUS_FULL;
        end else begin
            mirror_nbr[c.src][mirror_len[c.src]] = c.dest;
            mirror_wt[c.src][mirror_len[c.src]]  = c.weight;
            mirror_len[c.src] = mirror_len[c.src] + 1'b1;
        end
        return a;
    endfunction

    task automatic report_err(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // checker: predicts on every accepted command beat, compares every
    // accepted result beat with the oldest outstanding answer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_proc
        graph_answer_t want;
        graph_cmd_t    got_cmd;
        if (!aresetn) begin
            for (int n = 0; n < NODES; n++) mirror_len[n] = '0;
            mirror_node_count = wal_pkg::CNT_RESET;
        end else begin
            // the block is idle whenever the register is written
            if (cfg_valid && cfg_ready) mirror_node_count = cfg_data;
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report_err("result beat with nothing outstanding");
                end else begin
                    want = answer_q.pop_front();
                    if (m_found !== want.found)
                        report_err($sformatf("answer %0d found %b, want %b",
                                             answer_idx, m_found, want.found));
                    if (m_weight_out !== want.weight)
                        report_err($sformatf("answer %0d weight %h, want %h",
                                             answer_idx, m_weight_out, want.weight));
                    if (m_status !== want.status)
                        report_err($sformatf("answer %0d status %0d, want %0d",
                                             answer_idx, m_status, want.status));
                end
                answer_idx++;
            end
            if (s_valid && s_ready) begin
                got_cmd.command = s_command;
                got_cmd.src     = s_src_node;
                got_cmd.dest    = s_dest_node;
                got_cmd.weight  = s_edge_weight;
                answer_q.insert(answer_q.size(), apply_graph_cmd(got_cmd));
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of beats with random gaps, counted from each accept
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_proc
        graph_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // slot is free after this edge
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                s_valid       <= 1'b1;
                s_command     <= nxt.command;
                s_src_node    <= nxt.src;
                s_dest_node   <= nxt.dest;
                s_edge_weight <= nxt.weight;
                if (burst_left <= 1) begin
                    // some long bursts give stretches with no idling at all
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 10);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: switches between stall patterns, plus one long hold-off
    // that lets the block back up into its command input
    // ------------------------------------------------------------------
    int sink_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int in_seen   = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin : sink_proc
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_mode <= 0;
            mode_left <= 50;
            hold_left <= 0;
            in_seen   <= 0;
            hold_done <= 1'b0;
        end else begin
            if (s_valid && s_ready) in_seen <= in_seen + 1;
            if (!hold_done && in_seen >= HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= (hold_left == 1);
            end else begin
                if (mode_left == 0) begin
                    sink_mode <= $urandom_range(0, 3);
                    mode_left <= $urandom_range(20, 200);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (sink_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= (mode_left[1:0] == 2'd0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 4) == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no beat on any channel for too long ends the run
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog_proc
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic graph_cmd_t make_cmd(input logic [wal_pkg::CMD_W-1:0] cmd,
                                            input int src, input int dest,
                                            input logic [wal_pkg::WEIGHT_W-1:0] w);
        graph_cmd_t c;
        c.command = cmd;
        c.src     = wal_pkg::NODE_W'(src);
        c.dest    = wal_pkg::NODE_W'(dest);
        c.weight  = w;
        return c;
    endfunction

    // random command, biased to a hot source node so lists grow long
    function automatic graph_cmd_t rand_cmd(input int top, input int hot);
        graph_cmd_t c;
        int p;
        c.src    = wal_pkg::NODE_W'($urandom);
        c.dest   = wal_pkg::NODE_W'($urandom);
        c.weight = $urandom;
        p = $urandom_range(0, 99);
        if (p < 2)       c.command = wal_pkg::CMD_CLEAR;
        else if (p < 4)  c.command = CMD_UNUSED;
        else if (p < 52) c.command = wal_pkg::CMD_ADD;
        else             c.command = wal_pkg::CMD_LOOKUP;
        // mostly in range; the raw draw may land outside the nodes in use
        if (top > 0 && $urandom_range(0, 9) != 0) begin
            c.src  = ($urandom_range(0, 2) != 0) ? wal_pkg::NODE_W'(hot)
                                                 : wal_pkg::NODE_W'($urandom_range(0, top - 1));
            c.dest = wal_pkg::NODE_W'($urandom_range(0, top - 1));
        end
        case ($urandom_range(0, 7))
            0: c.weight = 32'h7fff_ffff;
            1: c.weight = 32'h8000_0000;
            2: c.weight = '0;
            3: c.weight = '1;
            default: ;
        endcase
        return c;
    endfunction

    // appends one command to the driver's pending list
    task automatic enqueue_cmd(input graph_cmd_t c);
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do @(negedge aclk);
        while (cmd_q.size() != 0 || s_valid || answer_q.size() != 0);
    endtask

    task automatic write_node_count(input logic [wal_pkg::CNT_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // one node count setting: an optional list fill run, then random traffic
    task automatic run_phase(input int count_val, input int n_rand);
        int top;
        int hot;
        int base;
        top = (count_val < NODES) ? count_val : NODES;
        wait_idle();
        write_node_count(wal_pkg::CNT_W'(count_val));
        hot = (top > 0) ? $urandom_range(0, top - 1) : 0;
        if (top > MAX_DEG) begin
            // neighbours on one node, distinct when top > MAX_DEG + 1, enough to overflow the list
            base = $urandom_range(0, top - 1);
            for (int k = 0; k < MAX_DEG + 2; k++)
                enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, hot, (base + k) % top, $urandom));
            for (int k = 0; k < 4; k++)
                enqueue_cmd(make_cmd(wal_pkg::CMD_LOOKUP, hot,
                                     (base + $urandom_range(0, MAX_DEG + 1)) % top,
                                     $urandom));
        end
        for (int k = 0; k < n_rand; k++) enqueue_cmd(rand_cmd(top, hot));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stim_proc
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the full node count
        write_node_count(wal_pkg::CNT_RESET);
        enqueue_cmd(make_cmd(wal_pkg::CMD_CLEAR, 63, 63, 32'hffff_ffff));
        enqueue_cmd(make_cmd(wal_pkg::CMD_LOOKUP, 63, 0, 32'h0));        // absent edge
        enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, 0, 63, 32'h7fff_ffff));   // append
        enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, 0, 63, 32'h8000_0000));   // update
        enqueue_cmd(make_cmd(wal_pkg::CMD_LOOKUP, 0, 63, 32'h0));
        enqueue_cmd(make_cmd(CMD_UNUSED, 0, 63, 32'h1234_5678));
        // fill node 5 to its limit, then a new neighbour and an update
        for (int k = 0; k < MAX_DEG; k++)
            enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, 5, 20 + k, $urandom));
        enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, 5, 50, 32'h5555_aaaa));   // list full
        enqueue_cmd(make_cmd(wal_pkg::CMD_ADD, 5, 20 + MAX_DEG - 1, 32'h0)); // update, full list
        enqueue_cmd(make_cmd(wal_pkg::CMD_CLEAR, 0, 0, 32'h0));
        enqueue_cmd(make_cmd(wal_pkg::CMD_LOOKUP, 0, 63, 32'h0));        // gone after clear

        // random part over several node counts, extremes included
        run_phase(64, 55);
        run_phase(1, 70);
        run_phase(17, 55);
        run_phase(0, 70);
        run_phase(127, 55);
        run_phase(2, 70);
        run_phase(33, 55);
        run_phase(100, 55);
        run_phase(64, 55);
        run_phase($urandom_range(1, 64), 60);

        // drain, then allow for the longest add latency
        wait_idle();
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
